FILE: rtl/esf_pkg.sv
// Shared widths and reset constants for the seeded EMA filter.
package esf_pkg;

  localparam int PRICE_W  = 24;                   // price sample
  localparam int FRAC_W   = 16;                   // fraction bits of the EMA
  localparam int EMA_W    = PRICE_W + FRAC_W;     // EMA word
  localparam int PERIOD_W = 8;                    // period register
  localparam int SUM_W    = 32;                   // seeding sum
  localparam int SF_W     = FRAC_W + 1;           // smoothing factor, Q0.16 plus unity
  localparam int ALU_W    = EMA_W + SF_W;         // shared adder, holds the full product
  localparam int DIVD_W   = SUM_W + FRAC_W;       // dividend of the seeding divide
  localparam int REM_W    = PERIOD_W + 1;         // remainder and divisor (period + 1)
  localparam int ITER_W   = $clog2(DIVD_W);       // step counter

  localparam logic [PERIOD_W-1:0] PERIOD_RESET = PERIOD_W'(1);
  localparam logic [SF_W-1:0]     SF_RESET     = SF_W'(1) << FRAC_W;

endpackage

FILE: rtl/esf_if.sv
// Valid/ready channel interfaces for sample words and result words.
interface esf_in_if;
  logic                        valid;
  logic                        ready;
  logic [esf_pkg::PRICE_W-1:0] price;
  logic                        series_start;

  modport source (output valid, price, series_start, input ready);
  modport sink   (input valid, price, series_start, output ready);
endinterface

interface esf_out_if;
  logic                      valid;
  logic                      ready;
  logic [esf_pkg::EMA_W-1:0] ema_value;
  logic                      seeded;
  logic                      period_error;

  modport source (output valid, ema_value, seeded, period_error, input ready);
  modport sink   (input valid, ema_value, seeded, period_error, output ready);
endinterface

FILE: rtl/ema_sma_seeded_filter_top.sv
// Seeded EMA filter top level: sequencer around one shared adder/subtractor.
//
// One price word is taken at a time; the block drops ready while it works on it.
// A sample that only adds into the seeding sum passes through the sum and emit
// states. The sample that completes the seeding period runs a restoring divide of
// (sum << 16) by the period, one quotient bit a cycle; this 48-step divide sets
// the worst-case rate. Every later sample runs a difference (with a negating
// step on a falling price), a 17-step shift-add multiply by the smoothing factor
// and an update step. A period error goes straight to the emit state. Writing a
// nonzero period recomputes the smoothing factor 2^17/(period+1) with the same
// 48-step divide, during which no sample is accepted; no sample is taken in the
// cycle of a period write either. A finished result sits in the output register
// while the next sample is already being taken in; a stalled receiver holds a
// finished result in the sequencer and so stalls the input.
module ema_sma_seeded_filter_top (
  input  logic                          clk,
  input  logic                          rst_n,
  esf_in_if.sink                        in_item,
  esf_out_if.source                     out_item,
  input  logic                          cfg_we,
  input  logic [esf_pkg::PERIOD_W-1:0]  cfg_wdata
);

  typedef enum logic [2:0] {
    S_IDLE, S_SUM, S_DIV, S_DIFF, S_NEG, S_MUL, S_FIN, S_EMIT
  } state_t;

  state_t state_r, state_nxt;

  logic [esf_pkg::PERIOD_W-1:0] period_r, period_nxt;
  logic [esf_pkg::SF_W-1:0]     sf_r, sf_nxt;
  logic [esf_pkg::PERIOD_W-1:0] count_r, count_nxt;
  logic [esf_pkg::SUM_W-1:0]    sum_r, sum_nxt;
  logic [esf_pkg::EMA_W-1:0]    ema_r, ema_nxt;

  logic [esf_pkg::PRICE_W-1:0]  price_r, price_nxt;
  logic [esf_pkg::DIVD_W-1:0]   q_r, q_nxt;
  logic [esf_pkg::REM_W-1:0]    rem_r, rem_nxt;
  logic [esf_pkg::REM_W-1:0]    divisor_r, divisor_nxt;
  logic                         div_cfg_r, div_cfg_nxt;
  logic [esf_pkg::ITER_W-1:0]   iter_r, iter_nxt;
  logic [esf_pkg::EMA_W-1:0]    mag_r, mag_nxt;
  logic                         up_r, up_nxt;
  logic [esf_pkg::ALU_W-1:0]    acc_r, acc_nxt;
  logic [esf_pkg::SF_W-1:0]     mplier_r, mplier_nxt;

  logic [esf_pkg::EMA_W-1:0]    res_ema_r, res_ema_nxt;
  logic                         res_seeded_r, res_seeded_nxt;
  logic                         res_err_r, res_err_nxt;

  logic                         out_valid_r, out_valid_nxt;
  logic [esf_pkg::EMA_W-1:0]    out_ema_r, out_ema_nxt;
  logic                         out_seeded_r, out_seeded_nxt;
  logic                         out_err_r, out_err_nxt;

  // shared adder/subtractor
  logic [esf_pkg::ALU_W-1:0]    alu_a, alu_b;
  logic                         alu_inv, alu_cin;
  logic [esf_pkg::ALU_W:0]      alu_sum;
  logic                         alu_carry;

  logic [esf_pkg::EMA_W-1:0]    target;
  logic [esf_pkg::REM_W:0]      rem_sh;
  logic [esf_pkg::ALU_W-esf_pkg::FRAC_W-1:0] prod_floor;
  logic                         prod_round;
  logic [esf_pkg::PERIOD_W-1:0] count_inc;
  logic [esf_pkg::PERIOD_W-1:0] count_eff;

  assign target     = {price_r, esf_pkg::FRAC_W'(0)};
  assign rem_sh     = {rem_r, q_r[esf_pkg::DIVD_W-1]};
  assign prod_floor = acc_r[esf_pkg::ALU_W-1:esf_pkg::FRAC_W];
  assign prod_round = |acc_r[esf_pkg::FRAC_W-1:0];
  assign count_inc  = count_r + esf_pkg::PERIOD_W'(1);
  assign count_eff  = in_item.series_start ? '0 : count_r;

  // operand selection for the shared unit
  always_comb begin
    alu_a   = '0;
    alu_b   = '0;
    alu_inv = 1'b0;
    alu_cin = 1'b0;
    unique case (state_r)
      S_SUM: begin
        alu_a = esf_pkg::ALU_W'(sum_r);
        alu_b = esf_pkg::ALU_W'(price_r);
      end
      S_DIV: begin
        alu_a   = esf_pkg::ALU_W'(rem_sh);
        alu_b   = esf_pkg::ALU_W'(divisor_r);
        alu_inv = 1'b1;
        alu_cin = 1'b1;
      end
      S_DIFF: begin
        alu_a   = esf_pkg::ALU_W'(target);
        alu_b   = esf_pkg::ALU_W'(ema_r);
        alu_inv = 1'b1;
        alu_cin = 1'b1;
      end
      S_NEG: begin
        alu_a   = esf_pkg::ALU_W'(ema_r);
        alu_b   = esf_pkg::ALU_W'(target);
        alu_inv = 1'b1;
        alu_cin = 1'b1;
      end
      S_MUL: begin
        alu_a = {acc_r[esf_pkg::ALU_W-2:0], 1'b0};
        alu_b = mplier_r[esf_pkg::SF_W-1] ? esf_pkg::ALU_W'(mag_r) : '0;
      end
      S_FIN: begin
        // up: ema + floor; down: ema - floor - round
        alu_a   = esf_pkg::ALU_W'(ema_r);
        alu_b   = esf_pkg::ALU_W'(prod_floor);
        alu_inv = !up_r;
        alu_cin = !up_r && !prod_round;
      end
      default: ;
    endcase
  end

  assign alu_sum   = {1'b0, alu_a} + {1'b0, alu_b ^ {esf_pkg::ALU_W{alu_inv}}}
                   + (esf_pkg::ALU_W + 1)'(alu_cin);
  assign alu_carry = alu_sum[esf_pkg::ALU_W];

  // sequencer
  always_comb begin
    state_nxt      = state_r;
    period_nxt     = period_r;
    sf_nxt         = sf_r;
    count_nxt      = count_r;
    sum_nxt        = sum_r;
    ema_nxt        = ema_r;
    price_nxt      = price_r;
    q_nxt          = q_r;
    rem_nxt        = rem_r;
    divisor_nxt    = divisor_r;
    div_cfg_nxt    = div_cfg_r;
    iter_nxt       = iter_r;
    mag_nxt        = mag_r;
    up_nxt         = up_r;
    acc_nxt        = acc_r;
    mplier_nxt     = mplier_r;
    res_ema_nxt    = res_ema_r;
    res_seeded_nxt = res_seeded_r;
    res_err_nxt    = res_err_r;
    out_valid_nxt  = out_valid_r && !out_item.ready;
    out_ema_nxt    = out_ema_r;
    out_seeded_nxt = out_seeded_r;
    out_err_nxt    = out_err_r;

    unique case (state_r)
      S_IDLE: begin
        if (cfg_we) begin
          // new period restarts the series and rebuilds the factor
          period_nxt = cfg_wdata;
          count_nxt  = '0;
          sum_nxt    = '0;
          ema_nxt    = '0;
          if (cfg_wdata == '0) begin
            sf_nxt = '0;
          end else begin
            divisor_nxt = esf_pkg::REM_W'(cfg_wdata) + esf_pkg::REM_W'(1);
            q_nxt       = esf_pkg::DIVD_W'(1) << (esf_pkg::FRAC_W + 1);
            rem_nxt     = '0;
            iter_nxt    = esf_pkg::ITER_W'(esf_pkg::DIVD_W - 1);
            div_cfg_nxt = 1'b1;
            state_nxt   = S_DIV;
          end
        end else if (in_item.valid) begin
          price_nxt = in_item.price;
          if (in_item.series_start) begin
            count_nxt = '0;
            sum_nxt   = '0;
            ema_nxt   = '0;
          end
          if (period_r == '0) begin
            res_ema_nxt    = '0;
            res_seeded_nxt = 1'b0;
            res_err_nxt    = 1'b1;
            state_nxt      = S_EMIT;
          end else if (count_eff < period_r) begin
            state_nxt = S_SUM;
          end else begin
            state_nxt = S_DIFF;
          end
        end
      end

      S_SUM: begin
        sum_nxt   = alu_sum[esf_pkg::SUM_W-1:0];
        count_nxt = count_inc;
        if (count_inc == period_r) begin
          q_nxt       = {alu_sum[esf_pkg::SUM_W-1:0], esf_pkg::FRAC_W'(0)};
          rem_nxt     = '0;
          divisor_nxt = esf_pkg::REM_W'(period_r);
          iter_nxt    = esf_pkg::ITER_W'(esf_pkg::DIVD_W - 1);
          div_cfg_nxt = 1'b0;
          state_nxt   = S_DIV;
        end else begin
          res_ema_nxt    = '0;
          res_seeded_nxt = 1'b0;
          res_err_nxt    = 1'b0;
          state_nxt      = S_EMIT;
        end
      end

      S_DIV: begin
        // restoring divide, one quotient bit a step
        if (alu_carry) begin
          rem_nxt = alu_sum[esf_pkg::REM_W-1:0];
          q_nxt   = {q_r[esf_pkg::DIVD_W-2:0], 1'b1};
        end else begin
          rem_nxt = rem_sh[esf_pkg::REM_W-1:0];
          q_nxt   = {q_r[esf_pkg::DIVD_W-2:0], 1'b0};
        end
        iter_nxt = iter_r - esf_pkg::ITER_W'(1);
        if (iter_r == '0) begin
          if (div_cfg_r) begin
            sf_nxt    = q_nxt[esf_pkg::SF_W-1:0];
            state_nxt = S_IDLE;
          end else begin
            ema_nxt        = q_nxt[esf_pkg::EMA_W-1:0];
            res_ema_nxt    = q_nxt[esf_pkg::EMA_W-1:0];
            res_seeded_nxt = 1'b1;
            res_err_nxt    = 1'b0;
            state_nxt      = S_EMIT;
          end
        end
      end

      S_DIFF: begin
        if (alu_carry) begin
          mag_nxt    = alu_sum[esf_pkg::EMA_W-1:0];
          up_nxt     = 1'b1;
          acc_nxt    = '0;
          mplier_nxt = sf_r;
          iter_nxt   = esf_pkg::ITER_W'(esf_pkg::SF_W - 1);
          state_nxt  = S_MUL;
        end else begin
          up_nxt    = 1'b0;
          state_nxt = S_NEG;
        end
      end

      S_NEG: begin
        mag_nxt    = alu_sum[esf_pkg::EMA_W-1:0];
        acc_nxt    = '0;
        mplier_nxt = sf_r;
        iter_nxt   = esf_pkg::ITER_W'(esf_pkg::SF_W - 1);
        state_nxt  = S_MUL;
      end

      S_MUL: begin
        // shift-add, factor msb first
        acc_nxt    = alu_sum[esf_pkg::ALU_W-1:0];
        mplier_nxt = {mplier_r[esf_pkg::SF_W-2:0], 1'b0};
        iter_nxt   = iter_r - esf_pkg::ITER_W'(1);
        if (iter_r == '0) begin
          state_nxt = S_FIN;
        end
      end

      S_FIN: begin
        if (up_r) begin
          ema_nxt = (|alu_sum[esf_pkg::ALU_W:esf_pkg::EMA_W]) ? '1
                                                              : alu_sum[esf_pkg::EMA_W-1:0];
        end else begin
          ema_nxt = alu_carry ? alu_sum[esf_pkg::EMA_W-1:0] : '0;
        end
        res_ema_nxt    = ema_nxt;
        res_seeded_nxt = 1'b1;
        res_err_nxt    = 1'b0;
        state_nxt      = S_EMIT;
      end

      S_EMIT: begin
        // wait for the output register to free up
        if (!out_valid_r || out_item.ready) begin
          out_valid_nxt  = 1'b1;
          out_ema_nxt    = res_ema_r;
          out_seeded_nxt = res_seeded_r;
          out_err_nxt    = res_err_r;
          state_nxt      = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      period_r    <= esf_pkg::PERIOD_RESET;
      sf_r        <= esf_pkg::SF_RESET;
      count_r     <= '0;
      sum_r       <= '0;
      ema_r       <= '0;
      div_cfg_r   <= 1'b0;
      iter_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      period_r    <= period_nxt;
      sf_r        <= sf_nxt;
      count_r     <= count_nxt;
      sum_r       <= sum_nxt;
      ema_r       <= ema_nxt;
      div_cfg_r   <= div_cfg_nxt;
      iter_r      <= iter_nxt;
      out_valid_r <= out_valid_nxt;
    end
    price_r      <= price_nxt;
    q_r          <= q_nxt;
    rem_r        <= rem_nxt;
    divisor_r    <= divisor_nxt;
    mag_r        <= mag_nxt;
    up_r         <= up_nxt;
    acc_r        <= acc_nxt;
    mplier_r     <= mplier_nxt;
    res_ema_r    <= res_ema_nxt;
    res_seeded_r <= res_seeded_nxt;
    res_err_r    <= res_err_nxt;
    out_ema_r    <= out_ema_nxt;
    out_seeded_r <= out_seeded_nxt;
    out_err_r    <= out_err_nxt;
  end

  // a period write takes the edge, so no word is taken with it
  assign in_item.ready          = (state_r == S_IDLE) && !cfg_we;
  assign out_item.valid         = out_valid_r;
  assign out_item.ema_value     = out_ema_r;
  assign out_item.seeded        = out_seeded_r;
  assign out_item.period_error  = out_err_r;

  // a sample word occupies the unit: no second word on the next edge
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_item.valid && in_item.ready |=> !in_item.ready)
    else $error("sample word accepted while previous one in flight");

  // a nonzero period write keeps samples out while the factor is built
  a_cfg_busy: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_we && (cfg_wdata != '0) |=> !in_item.ready)
    else $error("sample taken during smoothing factor divide");

  // unseeded or error words carry a zero value
  a_zero_unseeded: assert property (@(posedge clk) disable iff (!rst_n)
    out_item.valid && !out_item.seeded |-> out_item.ema_value == '0)
    else $error("nonzero EMA on an unseeded word");

  // error words are never flagged seeded
  a_err_unseeded: assert property (@(posedge clk) disable iff (!rst_n)
    out_item.valid && out_item.period_error |-> !out_item.seeded)
    else $error("period error word flagged seeded");

  // a valid period always has a factor ready once idle
  a_factor_ready: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) && (period_r != '0) |-> sf_r != '0)
    else $error("smoothing factor missing for nonzero period");

endmodule

FILE: tb/esf_checker.sv
// Scoreboard for the seeded EMA filter: follows the period register, predicts and checks result words.
module esf_checker (
  input  logic                         clk,
  input  logic                         rst_n,
  esf_in_if                            in_mon,
  esf_out_if                           out_mon,
  input  logic                         cfg_we,
  input  logic [esf_pkg::PERIOD_W-1:0] cfg_wdata,
  output int                           mismatch_cnt,
  output int                           pending_cnt
);

  localparam logic [63:0] EMA_TOP = (64'd1 << esf_pkg::EMA_W) - 64'd1;

  typedef struct packed {
    logic [esf_pkg::EMA_W-1:0] ema_value;
    logic                      seeded;
    logic                      period_error;
  } ema_word_t;

  // predictor state
  logic [esf_pkg::PERIOD_W-1:0] period_q;
  logic [esf_pkg::PERIOD_W-1:0] count_q;
  logic [esf_pkg::SUM_W-1:0]    sum_q;
  logic [esf_pkg::EMA_W-1:0]    ema_q;
  logic [esf_pkg::SF_W-1:0]     sf_q;

  ema_word_t ema_expected_q[$];

  task automatic restart_series();
    count_q = '0;
    sum_q   = '0;
    ema_q   = '0;
  endtask

  // smoothing factor is 2^17/(period+1), zero for an invalid period
  task automatic load_period(input logic [esf_pkg::PERIOD_W-1:0] p);
    period_q = p;
    if (p == '0) begin
      sf_q = '0;
    end else begin
      sf_q = esf_pkg::SF_W'((64'd1 << (esf_pkg::FRAC_W + 1)) / (64'(p) + 64'd1));
    end
    restart_series();
  endtask

  // one sample in, one result word out
  task automatic next_ema(input logic [esf_pkg::PRICE_W-1:0] price, input logic start,
                          output ema_word_t w);
    logic [63:0] target;
    logic [63:0] prod;
    logic [63:0] delta;
    logic [63:0] grown;
    w = '0;
    if (start) restart_series();
    if (period_q == '0) begin
      w.period_error = 1'b1;
    end else if (count_q < period_q) begin
      // still collecting the seeding average
      sum_q   = sum_q + esf_pkg::SUM_W'(price);
      count_q = count_q + 1'b1;
      if (count_q == period_q) begin
        ema_q       = esf_pkg::EMA_W'((64'(sum_q) << esf_pkg::FRAC_W) / 64'(period_q));
        w.ema_value = ema_q;
        w.seeded    = 1'b1;
      end
    end else begin
      // tracking: floor of the scaled step, i.e. round down when rising, up when falling
      target = 64'(price) << esf_pkg::FRAC_W;
      if (target >= 64'(ema_q)) begin
        prod  = (target - 64'(ema_q)) * 64'(sf_q);
        grown = 64'(ema_q) + (prod >> esf_pkg::FRAC_W);
        ema_q = (grown > EMA_TOP) ? '1 : esf_pkg::EMA_W'(grown);
      end else begin
        prod  = (64'(ema_q) - target) * 64'(sf_q);
        delta = (prod >> esf_pkg::FRAC_W)
              + ((prod[esf_pkg::FRAC_W-1:0] != '0) ? 64'd1 : 64'd0);
        ema_q = (delta > 64'(ema_q)) ? '0 : esf_pkg::EMA_W'(64'(ema_q) - delta);
      end
      w.ema_value = ema_q;
      w.seeded    = 1'b1;
    end
  endtask

  // one line per mismatch, and count it
  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("%0t: result %s got %0h, want %0h", $time, what, got, want);
    mismatch_cnt++;
  endtask

  always @(posedge clk) begin : watch
    ema_word_t want;
    if (!rst_n) begin
      load_period(esf_pkg::PERIOD_RESET);
      ema_expected_q.delete();
    end else begin
      // result side first: a word accepted now cannot come from a word taken now
      if (out_mon.valid && out_mon.ready) begin
        if (ema_expected_q.size() == 0) begin
          report_mismatch("word unexpected", 64'(out_mon.ema_value), 64'd0);
        end else begin
          want = ema_expected_q.pop_front();
          if (out_mon.ema_value !== want.ema_value)
            report_mismatch("ema_value", 64'(out_mon.ema_value), 64'(want.ema_value));
          if (out_mon.seeded !== want.seeded)
            report_mismatch("seeded", 64'(out_mon.seeded), 64'(want.seeded));
          if (out_mon.period_error !== want.period_error)
            report_mismatch("period_error", 64'(out_mon.period_error),
                            64'(want.period_error));
        end
      end
      if (cfg_we) load_period(cfg_wdata);
      if (in_mon.valid && in_mon.ready) begin
        next_ema(in_mon.price, in_mon.series_start, want);
        ema_expected_q.push_back(want);
      end
    end
    pending_cnt = ema_expected_q.size();
  end

endmodule

FILE: tb/tb_ema_sma_seeded_filter_top.sv
// Top of the seeded EMA filter bench: clock, reset, sample stimulus, sink pacing and verdict.
module tb_ema_sma_seeded_filter_top;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int DRAIN_CYCLES = 64;
  localparam int HOLD_CYCLES  = 300;

  typedef enum int {PACE_FREE, PACE_SRC_IDLE, PACE_SINK_STALL, PACE_BOTH} pace_t;

  logic                         clk;
  logic                         rst_n;
  logic                         cfg_we;
  logic [esf_pkg::PERIOD_W-1:0] cfg_wdata;
  int                           mismatches;
  int                           words_pending;
  int                           cycle_cnt;
  int                           src_idle_pct;
  int                           sink_stall_pct;
  logic                         hold_req;
  logic [esf_pkg::PRICE_W-1:0]  last_price;

  esf_in_if  in_ch ();
  esf_out_if out_ch ();

  ema_sma_seeded_filter_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_item   (in_ch),
    .out_item  (out_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  esf_checker u_scoreboard (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_mon       (in_ch),
    .out_mon      (out_ch),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .mismatch_cnt (mismatches),
    .pending_cnt  (words_pending)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // run guard
  initial cycle_cnt = 0;
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("[ema_sma_seeded_filter_top] ERROR");
      $finish;
    end
  end

  // result sink: random stalls, plus one long hold-off when asked
  initial begin : sink_pacing
    int   hold_left;
    logic hold_taken;
    hold_left  = 0;
    hold_taken = 1'b0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req && !hold_taken) begin
        hold_taken = 1'b1;
        hold_left  = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(0, 99) >= sink_stall_pct);
      end
    end
  end

  task automatic set_pace(input pace_t pc);
    case (pc)
      PACE_FREE: begin
        src_idle_pct = 0;  sink_stall_pct = 0;
      end
      PACE_SRC_IDLE: begin
        src_idle_pct = 69; sink_stall_pct = 0;
      end
      PACE_SINK_STALL: begin
        src_idle_pct = 0;  sink_stall_pct = 69;
      end
      default: begin
        src_idle_pct = 23; sink_stall_pct = 23;
      end
    endcase
  endtask

  // offer one sample word, return once it is taken
  task automatic send_sample(input logic [esf_pkg::PRICE_W-1:0] price, input logic start);
    @(negedge clk);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.price        <= price;
    in_ch.series_start <= start;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  // period is only written with nothing in flight
  task automatic write_period(input logic [esf_pkg::PERIOD_W-1:0] p);
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (words_pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= p;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // extremes, a drifting walk around the last price, or anything
  function automatic logic [esf_pkg::PRICE_W-1:0] pick_price();
    logic [esf_pkg::PRICE_W-1:0] v;
    case ($urandom_range(0, 7))
      0:       v = '0;
      1:       v = '1;
      2, 3:    v = last_price + esf_pkg::PRICE_W'($urandom_range(0, 511))
                   - esf_pkg::PRICE_W'(256);
      default: v = esf_pkg::PRICE_W'($urandom);
    endcase
    last_price = v;
    return v;
  endfunction

  // a run of series at one period; restarts are rare so most series seed and track
  task automatic run_phase(input logic [esf_pkg::PERIOD_W-1:0] p, input int n_words,
                           input pace_t pc);
    int   i;
    logic start;
    write_period(p);
    set_pace(pc);
    for (i = 0; i < n_words; i++) begin
      if (p == '0) start = ($urandom_range(0, 2) == 0);
      else         start = ($urandom_range(0, 4 * int'(p) + 8) == 0);
      send_sample(pick_price(), start);
    end
  endtask

  initial begin : stimulus
    rst_n              = 1'b0;
    cfg_we             = 1'b0;
    cfg_wdata          = '0;
    in_ch.valid        = 1'b0;
    in_ch.price        = '0;
    in_ch.series_start = 1'b0;
    hold_req           = 1'b0;
    last_price         = '0;
    set_pace(PACE_FREE);
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // reset period of one: the first sample seeds, then the EMA follows the price exactly
    send_sample('1, 1'b1);
    send_sample('0, 1'b0);
    send_sample('1, 1'b0);
    send_sample(esf_pkg::PRICE_W'(1), 1'b0);
    send_sample(esf_pkg::PRICE_W'(24'h800000), 1'b0);

    // invalid period: every sample gives an error word
    write_period('0);
    send_sample(esf_pkg::PRICE_W'(24'h123456), 1'b0);
    send_sample('1, 1'b1);
    send_sample('0, 1'b0);

    // period two: full-scale seed, falling step, restarts after seeding
    write_period(esf_pkg::PERIOD_W'(2));
    send_sample('1, 1'b0);
    send_sample('1, 1'b0);
    send_sample('0, 1'b0);
    send_sample(esf_pkg::PRICE_W'(5), 1'b1);
    send_sample(esf_pkg::PRICE_W'(7), 1'b0);
    send_sample(esf_pkg::PRICE_W'(9), 1'b0);
    send_sample(esf_pkg::PRICE_W'(24'hAAAAAA), 1'b1);
    send_sample(esf_pkg::PRICE_W'(24'h555555), 1'b0);

    // random series at several periods and pacing styles
    run_phase(esf_pkg::PERIOD_W'(3), 30, PACE_SRC_IDLE);
    run_phase('1, 205, PACE_BOTH);
    run_phase(esf_pkg::PERIOD_W'(1), 25, PACE_SINK_STALL);
    hold_req = 1'b1;
    run_phase(esf_pkg::PERIOD_W'(2), 35, PACE_FREE);
    run_phase('0, 8, PACE_SRC_IDLE);
    run_phase(esf_pkg::PERIOD_W'(16), 40, PACE_SINK_STALL);
    run_phase(esf_pkg::PERIOD_W'($urandom_range(4, 60)), 40, PACE_BOTH);

    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (words_pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (mismatches == 0 && words_pending == 0) begin
      $display("[ema_sma_seeded_filter_top] OK");
    end else begin
      $display("[ema_sma_seeded_filter_top] ERROR");
    end
    $finish;
  end

endmodule
